>>> hdl/mdr_pkg.sv
package mdr_pkg;

  // APB register map, one 32-bit register every 4 bytes
  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_STEER_DZ  = 3'd0,
    REG_POWER_DZ  = 3'd1,
    REG_CENTER    = 3'd2,
    REG_MAX_TURN  = 3'd3,
    REG_DIFF_GAIN = 3'd4,
    REG_RAMP_UP   = 3'd5,
    REG_RAMP_DOWN = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] steer_deadzone;
    logic [14:0] power_deadzone;
    logic [7:0]  servo_center;
    logic [5:0]  max_turn_deg;
    logic [15:0] diff_gain;
    logic [7:0]  ramp_up_step;
    logic [7:0]  ramp_down_step;
  } cfg_t;

  localparam logic [14:0] RST_STEER_DZ  = 15'd4915;
  localparam logic [14:0] RST_POWER_DZ  = 15'd1638;
  localparam logic [7:0]  RST_CENTER    = 8'd90;
  localparam logic [5:0]  RST_MAX_TURN  = 6'd30;
  localparam logic [15:0] RST_DIFF_GAIN = 16'd256;
  localparam logic [7:0]  RST_RAMP_UP   = 8'd25;
  localparam logic [7:0]  RST_RAMP_DOWN = 8'd100;

  // shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // tangent table, Q2.16
  localparam int          TAN_W      = 18;
  localparam int          TAN_IDX_W  = 8;
  localparam logic [17:0] TAN_MAX    = 18'd262143;
  localparam logic [17:0] TAN_SMALL  = 18'd3280;
  localparam int          TAN_STEEP  = 304;
  // largest index the angle can produce: (32768 * 63 + 4096) >> 13, plus one
  localparam int          TAN_REACH  = ((32768 * 63 + 4096) >> 13) + 1;
  localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] TAN_STEP   = PI_Q60 / 64'd720;

  localparam logic [21:0] SMALL_ANGLE = 22'd18775;
  localparam logic [21:0] IDX_ROUND   = 22'd4096;
  localparam logic [15:0] FACTOR_MAX  = 16'd58982;
  localparam logic [16:0] UNITY_Q16   = 17'd65536;
  localparam logic [31:0] MAG_CAP     = 32'h8000_0000;
  localparam logic [7:0]  PWM_FULL    = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_LOOK,
    ST_MUL_F,
    ST_GAIN_IN,
    ST_SCALE_IN,
    ST_GAIN_OUT,
    ST_SCALE_OUT,
    ST_RAMP
  } state_t;

endpackage

>>> hdl/mdr_if.sv
interface mdr_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] power;
  logic signed [15:0] steer;

  modport source (output valid, output power, output steer, input ready);
  modport sink   (input valid, input power, input steer, output ready);
endinterface

interface mdr_drv_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] servo_angle;
  logic signed [8:0] left_drive;
  logic signed [8:0] right_drive;

  modport source (output valid, output servo_angle, output left_drive, output right_drive,
                  input ready);
  modport sink   (input valid, input servo_angle, input left_drive, input right_drive,
                  output ready);
endinterface

>>> hdl/mdr_cfg.sv
module mdr_cfg import mdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_deadzone <= RST_STEER_DZ;
      cfg.power_deadzone <= RST_POWER_DZ;
      cfg.servo_center   <= RST_CENTER;
      cfg.max_turn_deg   <= RST_MAX_TURN;
      cfg.diff_gain      <= RST_DIFF_GAIN;
      cfg.ramp_up_step   <= RST_RAMP_UP;
      cfg.ramp_down_step <= RST_RAMP_DOWN;
    end else if (wr) begin
      unique case (idx)
        REG_STEER_DZ:  cfg.steer_deadzone <= pwdata[14:0];
        REG_POWER_DZ:  cfg.power_deadzone <= pwdata[14:0];
        REG_CENTER:    cfg.servo_center   <= pwdata[7:0];
        REG_MAX_TURN:  cfg.max_turn_deg   <= pwdata[5:0];
        REG_DIFF_GAIN: cfg.diff_gain      <= pwdata[15:0];
        REG_RAMP_UP:   cfg.ramp_up_step   <= pwdata[7:0];
        REG_RAMP_DOWN: cfg.ramp_down_step <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEER_DZ:  prdata = {17'd0, cfg.steer_deadzone};
      REG_POWER_DZ:  prdata = {17'd0, cfg.power_deadzone};
      REG_CENTER:    prdata = {24'd0, cfg.servo_center};
      REG_MAX_TURN:  prdata = {26'd0, cfg.max_turn_deg};
      REG_DIFF_GAIN: prdata = {16'd0, cfg.diff_gain};
      REG_RAMP_UP:   prdata = {24'd0, cfg.ramp_up_step};
      REG_RAMP_DOWN: prdata = {24'd0, cfg.ramp_down_step};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/mdr_mul.sv
module mdr_mul import mdr_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod
);

  // unsigned 32x18, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

>>> hdl/mdr_tan_rom.sv
module mdr_tan_rom import mdr_pkg::*; #(
  parameter int TAN_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rd,
  input  logic [TAN_IDX_W-1:0] idx,
  output logic [TAN_W-1:0]     tan_q
);

  // only indices the angle can reach are built
  localparam int DEPTH = (TAN_ENTRIES < TAN_REACH) ? TAN_ENTRIES : TAN_REACH;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 Taylor sum, truncating at every term, stops at a zero term
  function automatic logic signed [63:0] taylor(input logic [63:0] x, input logic [63:0] t0,
                                                input int n0);
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic               neg;
    int                 n;
    t   = t0;
    n   = n0;
    sum = $signed(t0);
    neg = 1'b1;
    for (int k = 0; k < 32; k++) begin
      if (t != 64'd0 && n < 60) begin
        t   = (((t * x) >> 30) * x) >> 30;
        t   = udiv(t, 64'(n + 1) * 64'(n + 2));
        n   = n + 2;
        sum = neg ? sum - $signed(t) : sum + $signed(t);
        neg = !neg;
      end
    end
    return sum;
  endfunction

  function automatic logic [TAN_W-1:0] tan_entry(input int i);
    logic [63:0]        x;
    logic signed [63:0] sn;
    logic signed [63:0] cs;
    logic [63:0]        q;
    if (i >= TAN_STEEP) begin
      return TAN_MAX;
    end
    x  = (64'(i) * TAN_STEP) >> 30;
    sn = taylor(x, x, 1);
    cs = taylor(x, 64'd1 << 30, 0);
    if (sn < 0) begin
      sn = '0;
    end
    if (cs <= 0) begin
      return TAN_MAX;
    end
    q = udiv((64'(sn) << 16) + (64'(cs) >> 1), 64'(cs));
    return (q > 64'(TAN_MAX)) ? TAN_MAX : q[TAN_W-1:0];
  endfunction

  logic [TAN_W-1:0]     rom [DEPTH];
  logic [TAN_IDX_W-1:0] idx_c;

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    localparam logic [TAN_W-1:0] ENTRY = tan_entry(g);
    assign rom[g] = ENTRY;
  end

  assign idx_c = (idx > TAN_IDX_W'(DEPTH - 1)) ? TAN_IDX_W'(DEPTH - 1) : idx;

  always_ff @(posedge clk) begin
    if (rd) begin
      tan_q <= rom[idx_c[$clog2(DEPTH)-1:0]];
    end
  end

endmodule

>>> hdl/steer_differential_mixer_ramp.sv
// Channel  Dir  Handshake     Word
// cmd      in   valid/ready   power, steer (Q1.15 signed)
// drv      out  valid/ready   servo_angle, left_drive, right_drive (9b signed)
// apb      in   psel/penable  seven config registers at 4*i, write in access cycle
//
// From accept to result register a word steps through the sequencer, paced by the
// single shared 32x18 multiplier used six times in sequence (angle, gain, two per wheel).
// cmd.ready is high only while the sequencer idles; a held result does not block it.
// If drv is stalled when a new result is done, the sequencer waits in its last
// step and the wheel levels are not updated until the result register frees.
// Synchronous active-high rst clears levels, sequencer and result valid, resets config.
module steer_differential_mixer_ramp import mdr_pkg::*; #(
  parameter int TAN_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst,
  mdr_cmd_if.sink            cmd,
  mdr_drv_if.source          drv,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;

  mdr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state, state_next;

  // latched command after deadzones
  logic [16:0]       p_mag;
  logic              p_neg;
  logic [16:0]       s_mag;
  logic              s_neg;
  logic              s_zero;
  // intermediate results
  logic              ang_small;
  logic [15:0]       f_reg;
  logic [7:0]        d_in;
  logic signed [8:0] servo_reg;
  // wheel levels
  logic signed [8:0] left_level, right_level;
  // result register
  logic              out_valid;
  logic signed [8:0] out_servo, out_left, out_right;

  // shared multiplier
  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  mdr_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // tangent lookup, registered read
  logic                 rom_rd;
  logic [TAN_IDX_W-1:0] rom_idx;
  logic [TAN_W-1:0]     tan_q;

  mdr_tan_rom #(.TAN_ENTRIES(TAN_ENTRIES)) u_rom (
    .clk   (clk),
    .rd    (rom_rd),
    .idx   (rom_idx),
    .tan_q (tan_q)
  );

  // ---------------- input deadzones ----------------
  logic        in_fire;
  logic [16:0] p_ext, s_ext, p_abs, s_abs;
  logic        p_dead, s_dead;

  assign in_fire   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);

  always_comb begin
    p_ext  = {cmd.power[15], cmd.power};
    s_ext  = {cmd.steer[15], cmd.steer};
    p_abs  = cmd.power[15] ? (17'd0 - p_ext) : p_ext;
    s_abs  = cmd.steer[15] ? (17'd0 - s_ext) : s_ext;
    p_dead = p_abs < {2'b00, cfg.power_deadzone};
    s_dead = s_abs < {2'b00, cfg.steer_deadzone};
  end

  // ---------------- per-step datapath ----------------
  logic [21:0]        angle;      // |s| * max_turn, degrees in Q15
  logic [21:0]        angle_rnd;
  logic [9:0]         defl;
  logic signed [9:0]  servo_sum;
  logic signed [8:0]  servo_sat;
  logic [TAN_W-1:0]   tan_sel;
  logic [15:0]        f_c;        // differential factor, Q16
  logic [31:0]        mag_cap;    // |p| * g capped at 2^31
  logic [7:0]         d_out;
  logic signed [9:0]  tgt_in, tgt_out, tgt_left, tgt_right;
  logic               commit;

  always_comb begin
    angle     = prod[21:0];
    angle_rnd = angle + IDX_ROUND;
    rom_idx   = angle_rnd[20:13];               // nearest quarter degree
    defl      = {3'd0, angle[21:15]};
    servo_sum = $signed({2'b00, cfg.servo_center}) +
                (s_neg ? -$signed(defl) : $signed(defl));
    if (servo_sum > 10'sd255) begin
      servo_sat = 9'sd255;
    end else if (servo_sum < -10'sd256) begin
      servo_sat = -9'sd256;
    end else begin
      servo_sat = servo_sum[8:0];
    end

    tan_sel = ang_small ? TAN_SMALL : tan_q;

    // (T * gain) >> 8, saturated at 0.9; straight driving uses unity gain
    if (s_zero) begin
      f_c = 16'd0;
    end else if (prod[MUL_P_W-1:8] > (MUL_P_W - 8)'(FACTOR_MAX)) begin
      f_c = FACTOR_MAX;
    end else begin
      f_c = prod[23:8];
    end

    mag_cap = (prod > MUL_P_W'(MAG_CAP)) ? MAG_CAP : prod[31:0];
    d_out   = prod[38:31];                      // (m * 255) >> 31

    tgt_in    = p_neg ? -$signed({2'b00, d_in}) : $signed({2'b00, d_in});
    tgt_out   = p_neg ? -$signed({2'b00, d_out}) : $signed({2'b00, d_out});
    // right turn: right wheel inside
    tgt_right = s_neg ? tgt_out : tgt_in;
    tgt_left  = s_neg ? tgt_in : tgt_out;
  end

  function automatic logic signed [8:0] ramp_step(input logic signed [8:0] level,
                                                 input logic signed [9:0] target,
                                                 input logic [7:0]        up,
                                                 input logic [7:0]        down);
    logic signed [10:0] diff;
    logic signed [10:0] lvl;
    logic signed [10:0] ups;
    logic signed [10:0] dns;
    lvl  = $signed({{2{level[8]}}, level});
    diff = $signed({target[9], target}) - lvl;
    ups  = $signed({3'b000, up});
    dns  = $signed({3'b000, down});
    if (diff > 11'sd0) begin
      lvl = lvl + ((diff > ups) ? ups : diff);
    end else if (diff < 11'sd0) begin
      lvl = lvl - ((-diff > dns) ? dns : -diff);
    end
    return lvl[8:0];
  endfunction

  // ---------------- sequencer ----------------
  assign commit = (state == ST_RAMP) && (!out_valid || drv.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    rom_rd     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin                           // angle = |s| * max_turn
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(s_mag);
        mul_b      = MUL_B_W'(cfg.max_turn_deg);
        state_next = ST_LOOK;
      end
      ST_LOOK: begin                            // servo, table read
        rom_rd     = 1'b1;
        state_next = ST_MUL_F;
      end
      ST_MUL_F: begin                           // T * gain
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(cfg.diff_gain);
        mul_b      = tan_sel;
        state_next = ST_GAIN_IN;
      end
      ST_GAIN_IN: begin                         // |p| * (1 - f)
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(p_mag);
        mul_b      = MUL_B_W'(UNITY_Q16 - {1'b0, f_c});
        state_next = ST_SCALE_IN;
      end
      ST_SCALE_IN: begin
        mul_en     = 1'b1;
        mul_a      = mag_cap;
        mul_b      = MUL_B_W'(PWM_FULL);
        state_next = ST_GAIN_OUT;
      end
      ST_GAIN_OUT: begin                        // |p| * (1 + f)
        mul_en     = 1'b1;
        mul_a      = MUL_A_W'(p_mag);
        mul_b      = MUL_B_W'(UNITY_Q16 + {1'b0, f_reg});
        state_next = ST_SCALE_OUT;
      end
      ST_SCALE_OUT: begin
        mul_en     = 1'b1;
        mul_a      = mag_cap;
        mul_b      = MUL_B_W'(PWM_FULL);
        state_next = ST_RAMP;
      end
      ST_RAMP: begin                            // wait for a free result slot
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // payload captures
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_mag  <= p_dead ? 17'd0 : p_abs;
      p_neg  <= cmd.power[15] && !p_dead;
      s_mag  <= s_dead ? 17'd0 : s_abs;
      s_neg  <= cmd.steer[15] && !s_dead;
      // zero steering drives straight even with no deadzone
      s_zero <= s_dead || (cmd.steer == 16'sd0);
    end
    if (state == ST_LOOK) begin
      ang_small <= angle < SMALL_ANGLE;         // below 0.01 rad
      servo_reg <= servo_sat;
    end
    if (state == ST_GAIN_IN) begin
      f_reg <= f_c;
    end
    if (state == ST_GAIN_OUT) begin
      d_in <= prod[38:31];
    end
    if (commit) begin
      out_servo <= servo_reg;
      out_left  <= ramp_step(left_level, tgt_left, cfg.ramp_up_step, cfg.ramp_down_step);
      out_right <= ramp_step(right_level, tgt_right, cfg.ramp_up_step, cfg.ramp_down_step);
    end
  end

  // levels and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_level  <= '0;
      right_level <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (commit) begin
        left_level  <= ramp_step(left_level, tgt_left, cfg.ramp_up_step, cfg.ramp_down_step);
        right_level <= ramp_step(right_level, tgt_right, cfg.ramp_up_step,
                                 cfg.ramp_down_step);
        out_valid   <= 1'b1;
      end else if (drv.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign drv.valid       = out_valid;
  assign drv.servo_angle = out_servo;
  assign drv.left_drive  = out_left;
  assign drv.right_drive = out_right;

`ifndef NO_ASSERTIONS
  // one word at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !cmd.ready)
    else $error("cmd accepted while sequencer busy");

  // levels move only when a result is written
  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(left_level) && $stable(right_level))
    else $error("wheel level changed without a result");

  // factor never exceeds 0.9 and is zero when driving straight
  a_factor_sat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCALE_OUT) |-> (f_reg <= FACTOR_MAX) && (!s_zero || f_reg == 16'd0))
    else $error("differential factor out of range");

  // levels never fall below -255, the bottom of the PWM range
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    commit |=> (left_level >= -9'sd255) && (right_level >= -9'sd255))
    else $error("wheel level below -255");
`endif

endmodule

>>> verif/steer_differential_mixer_ramp_tb.sv
`timescale 1ns / 1ps

module steer_differential_mixer_ramp_tb import mdr_pkg::*; ();

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int TAN_ENTRIES  = 256;
  localparam int REG_UNUSED   = 7;       // decoded by nobody, writes must vanish
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 188;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off, fills the block
  localparam int DRAIN_SLACK  = 16;      // margin over the sequencer's accept-to-result latency
  localparam int WATCHDOG_NS  = 5_000_000;

  typedef longint unsigned u64_t;

  // fixed-point constants of the mixer math
  localparam u64_t ANGLE_STEP_Q60 = 64'h3243_F6A8_885A_308D / 64'd720; // quarter degree
  localparam u64_t ONE_Q30        = 64'd1 << 30;
  localparam u64_t TAN_CEIL_Q16   = 64'd262143;
  localparam u64_t TAN_SMALL_Q16  = 64'd3280;        // tan(0.05)
  localparam int   SMALL_ANG_Q15  = 18775;           // 0.01 rad in degrees, Q15
  localparam int   IDX_HALF_Q13   = 4096;            // round to nearest table entry
  localparam u64_t FACTOR_CAP     = 64'd58982;       // 0.9 in Q16
  localparam u64_t UNITY_Q16      = 64'd65536;
  localparam u64_t MAG_CEIL       = 64'd1 << 31;
  localparam int   STEEP_IDX      = 304;             // 76 degrees and up saturate

  typedef struct {
    logic signed [8:0] servo_angle;
    logic signed [8:0] left_drive;
    logic signed [8:0] right_drive;
  } drive_word_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of config and wheel levels, predicts one
  // drive word per accepted command word and checks them in order.
  // ---------------------------------------------------------------------------
  class drive_checker;
    cfg_t        cfg;
    int          left_lvl;
    int          right_lvl;
    logic [17:0] tan_q16 [TAN_ENTRIES];
    drive_word_t drives_due [$];
    int          errors;

    function new();
      cfg.steer_deadzone = RST_STEER_DZ;
      cfg.power_deadzone = RST_POWER_DZ;
      cfg.servo_center   = RST_CENTER;
      cfg.max_turn_deg   = RST_MAX_TURN;
      cfg.diff_gain      = RST_DIFF_GAIN;
      cfg.ramp_up_step   = RST_RAMP_UP;
      cfg.ramp_down_step = RST_RAMP_DOWN;
      left_lvl  = 0;
      right_lvl = 0;
      errors    = 0;
      foreach (tan_q16[i]) tan_q16[i] = tan_entry(i);
    endfunction

    // alternating Taylor sum in Q30, every step truncating
    function longint series_q30(u64_t x, u64_t term, int unsigned n);
      longint sum;
      bit     neg;
      sum = longint'(term);
      neg = 1'b1;
      while (term != 0 && n < 60) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / u64_t'((n + 1) * (n + 2));
        n += 2;
        sum = neg ? sum - longint'(term) : sum + longint'(term);
        neg = !neg;
      end
      return sum;
    endfunction

    // tan(i quarter degrees) in Q2.16
    function logic [17:0] tan_entry(int unsigned i);
      u64_t   x, q;
      longint sn, cs;
      if (i >= STEEP_IDX) return TAN_CEIL_Q16[17:0];
      x  = (u64_t'(i) * ANGLE_STEP_Q60) >> 30;
      sn = series_q30(x, x, 1);
      cs = series_q30(x, ONE_Q30, 0);
      if (sn < 0) sn = 0;
      if (cs <= 0) return TAN_CEIL_Q16[17:0];
      q = ((u64_t'(sn) << 16) + u64_t'(cs) / 2) / u64_t'(cs);
      return (q > TAN_CEIL_Q16) ? TAN_CEIL_Q16[17:0] : q[17:0];
    endfunction

    // power times a Q16 gain, capped at full scale, scaled to 255
    function int wheel_drive(int p, u64_t g);
      u64_t mag, m;
      int   d;
      mag = (p < 0) ? u64_t'(-p) : u64_t'(p);
      m   = mag * g;
      if (m > MAG_CEIL) m = MAG_CEIL;
      d = int'((m * 64'd255) >> 31);
      return (p < 0) ? -d : d;
    endfunction

    function int slew(int lvl, int target);
      int diff, up, dn;
      diff = target - lvl;
      up   = int'(cfg.ramp_up_step);
      dn   = int'(cfg.ramp_down_step);
      if (diff > 0)      lvl += (diff > up) ? up : diff;
      else if (diff < 0) lvl -= (-diff > dn) ? dn : -diff;
      return lvl;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      case (idx)
        REG_STEER_DZ:  cfg.steer_deadzone = value[14:0];
        REG_POWER_DZ:  cfg.power_deadzone = value[14:0];
        REG_CENTER:    cfg.servo_center   = value[7:0];
        REG_MAX_TURN:  cfg.max_turn_deg   = value[5:0];
        REG_DIFF_GAIN: cfg.diff_gain      = value[15:0];
        REG_RAMP_UP:   cfg.ramp_up_step   = value[7:0];
        REG_RAMP_DOWN: cfg.ramp_down_step = value[7:0];
        default: ;
      endcase
    endfunction

    // command word accepted: predict the drive word it produces
    function void note_command(logic signed [15:0] power, logic signed [15:0] steer);
      int          p, s, pa, sa, defl, servo, lt, rt, inner, outer;
      int unsigned ang, idx;
      u64_t        tq, fw, f;
      drive_word_t w;
      p  = power;
      s  = steer;
      pa = (p < 0) ? -p : p;
      sa = (s < 0) ? -s : s;
      if (sa < int'(cfg.steer_deadzone)) begin
        s  = 0;
        sa = 0;
      end
      if (pa < int'(cfg.power_deadzone)) p = 0;

      ang   = sa * int'(cfg.max_turn_deg);
      defl  = int'(ang >> 15);
      servo = int'(cfg.servo_center) + ((s < 0) ? -defl : defl);
      if (servo > 255)  servo = 255;
      if (servo < -256) servo = -256;

      if (s == 0) begin
        lt = wheel_drive(p, UNITY_Q16);
        rt = lt;
      end else begin
        if (ang < SMALL_ANG_Q15) begin
          tq = TAN_SMALL_Q16;
        end else begin
          idx = (ang + IDX_HALF_Q13) >> 13;
          if (idx > TAN_ENTRIES - 1) idx = TAN_ENTRIES - 1;
          tq = tan_q16[idx];
        end
        fw    = (tq * u64_t'(cfg.diff_gain)) >> 8;
        f     = (fw > FACTOR_CAP) ? FACTOR_CAP : fw;
        inner = wheel_drive(p, UNITY_Q16 - f);
        outer = wheel_drive(p, UNITY_Q16 + f);
        if (s > 0) begin
          rt = inner;
          lt = outer;
        end else begin
          lt = inner;
          rt = outer;
        end
      end

      left_lvl  = slew(left_lvl, lt);
      right_lvl = slew(right_lvl, rt);
      w.servo_angle = servo[8:0];
      w.left_drive  = left_lvl[8:0];
      w.right_drive = right_lvl[8:0];
      drives_due.push_back(w);
    endfunction

    function void compare_field(string name, logic signed [8:0] want,
                                logic signed [8:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_drive(logic signed [8:0] servo, logic signed [8:0] left,
                              logic signed [8:0] right);
      drive_word_t want;
      if (drives_due.size() == 0) begin
        $display("%0t: unexpected drive word: expected none, got servo %0d left %0d right %0d",
                 $time, servo, left, right);
        errors++;
        return;
      end
      want = drives_due.pop_front();
      compare_field("servo_angle", want.servo_angle, servo);
      compare_field("left_drive",  want.left_drive,  left);
      compare_field("right_drive", want.right_drive, right);
    endfunction

    function int pending();
      return drives_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  mdr_cmd_if cmd ();
  mdr_drv_if drv ();

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  steer_differential_mixer_ramp #(.TAN_ENTRIES(TAN_ENTRIES)) uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .drv     (drv),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  drive_checker sb = new();

  // idle percentages of the current phase; hold_req asks the receiver for a
  // hold-off, which it then counts down on its own
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_req   = 0;
  int hold_left  = 0;

  // ---------------------------------------------------------------------------
  // Receiver: checks every accepted drive word, then decides the next ready.
  // Values read here are the ones from before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && drv.valid && drv.ready)
      sb.check_drive(drv.servo_angle, drv.left_drive, drv.right_drive);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      drv.ready <= 1'b0;
      hold_left--;
    end else begin
      drv.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // offer one command word, with random idle cycles in front; the prediction is
  // made at the edge where the word is taken
  task automatic send_command(input logic signed [15:0] pw, input logic signed [15:0] st);
    while ($urandom_range(99) < send_idle) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.power <= pw;
    cmd.steer <= st;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    sb.note_command(pw, st);
  endtask

  // stop offering and wait until every drive word is back, plus slack so the
  // sequencer is surely idle before any register write
  task automatic wait_drain();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // setup + access; psel stays up so writes can go back to back
  task automatic apb_write(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx << 2);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  // all registers, junk in the unused upper bits, plus one write to the hole
  task automatic write_config(input cfg_t c);
    apb_write(REG_STEER_DZ,  {17'($urandom), c.steer_deadzone});
    apb_write(REG_POWER_DZ,  {17'($urandom), c.power_deadzone});
    apb_write(REG_CENTER,    {24'($urandom), c.servo_center});
    apb_write(REG_MAX_TURN,  {26'($urandom), c.max_turn_deg});
    apb_write(REG_DIFF_GAIN, {16'($urandom), c.diff_gain});
    apb_write(REG_RAMP_UP,   {24'($urandom), c.ramp_up_step});
    apb_write(REG_RAMP_DOWN, {24'($urandom), c.ramp_down_step});
    apb_write(REG_UNUSED,    $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic cfg_t reset_cfg();
    cfg_t c;
    c.steer_deadzone = RST_STEER_DZ;
    c.power_deadzone = RST_POWER_DZ;
    c.servo_center   = RST_CENTER;
    c.max_turn_deg   = RST_MAX_TURN;
    c.diff_gain      = RST_DIFF_GAIN;
    c.ramp_up_step   = RST_RAMP_UP;
    c.ramp_down_step = RST_RAMP_DOWN;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.steer_deadzone = 15'($urandom_range(12000));
    c.power_deadzone = 15'($urandom_range(12000));
    c.servo_center   = 8'($urandom_range(255));
    c.max_turn_deg   = 6'($urandom_range(63));
    c.diff_gain      = $urandom_range(1) ? 16'($urandom_range(1024)) : 16'($urandom);
    c.ramp_up_step   = $urandom_range(3) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 8));
    c.ramp_down_step = $urandom_range(3) ? 8'($urandom_range(1, 255)) : 8'($urandom_range(1, 8));
    return c;
  endfunction

  // Q1.15 command: full scale, zero, right around the deadzone edge, or anything
  function automatic logic signed [15:0] pick_q15(input logic [14:0] dz);
    int v;
    case ($urandom_range(9))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3, 4: begin
        v = int'(dz) - 1 + int'($urandom_range(2));
        if ($urandom_range(1)) v = -v;
      end
      default: v = int'($urandom_range(65535)) - 32768;
    endcase
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t               c;
    int                 run_left;
    logic signed [15:0] pw, st;

    rst       <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.power <= '0;
    cmd.steer <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset config, no idling ---
    send_command(16'sd0, 16'sd0);
    send_command(16'sd32767, 16'sd0);          // straight, full forward
    send_command(-16'sd32768, 16'sd0);         // full negative power, never dead
    send_command(16'sd1637, 16'sd4914);        // both just inside their deadzones
    send_command(-16'sd1638, -16'sd4915);      // both right on the deadzone edge
    send_command(16'sd32767, 16'sd32767);      // hard right
    send_command(16'sd32767, -16'sd32768);     // hard left, full negative steer
    send_command(-16'sd32768, 16'sd16384);     // reversing in a turn
    send_command(16'sd0, -16'sd32768);         // turn with no power
    send_command(-16'sd1, 16'sd1);
    wait_drain();

    // --- no deadzones, servo pushed past 255, factor saturated, fast ramps ---
    c = reset_cfg();
    c.steer_deadzone = '0;
    c.power_deadzone = '0;
    c.servo_center   = 8'd255;
    c.max_turn_deg   = 6'd63;
    c.diff_gain      = 16'hFFFF;
    c.ramp_up_step   = 8'd255;
    c.ramp_down_step = 8'd255;
    write_config(c);
    send_command(16'sd32767, 16'sd32767);      // servo saturates
    send_command(16'sd32767, 16'sd297);        // angle under 0.01 rad
    send_command(-16'sd32768, -16'sd299);      // first angle above it
    send_command(16'sd12345, -16'sd298);
    send_command(-16'sd32768, 16'sd1);
    send_command(16'sd32767, -16'sd1);
    wait_drain();

    // zero gain: both wheels equal even in a turn
    c.diff_gain = '0;
    write_config(c);
    send_command(16'sd20000, 16'sd20000);
    wait_drain();

    // zero ramp steps hold the levels where they are
    c.ramp_up_step   = '0;
    c.ramp_down_step = '0;
    write_config(c);
    send_command(16'sd32767, 16'sd0);
    send_command(-16'sd32768, 16'sd0);
    wait_drain();
    c.ramp_down_step = 8'd7;
    c.servo_center   = '0;
    write_config(c);
    send_command(-16'sd32768, 16'sd0);
    send_command(16'sd32767, 16'sd5000);
    send_command(16'sd0, -16'sd32768);         // servo goes below zero
    wait_drain();

    // --- random phases ---
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          c = reset_cfg();
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          c.steer_deadzone = '0;
          c.power_deadzone = '0;
          c.servo_center   = '0;
          c.max_turn_deg   = '0;
          c.diff_gain      = '0;
          c.ramp_up_step   = 8'd1;
          c.ramp_down_step = 8'd1;
          send_idle  = 57;
          recv_stall = 0;
        end
        2: begin
          c.steer_deadzone = 15'h7FFF;
          c.power_deadzone = 15'h7FFF;
          c.servo_center   = 8'hFF;
          c.max_turn_deg   = 6'h3F;
          c.diff_gain      = 16'hFFFF;
          c.ramp_up_step   = 8'hFF;
          c.ramp_down_step = 8'hFF;
          send_idle  = 0;
          recv_stall = 57;
        end
        4: begin
          c = random_cfg();
          send_idle  = 0;
          recv_stall = 0;
        end
        default: begin
          c = random_cfg();
          send_idle  = 34;
          recv_stall = 34;
        end
      endcase
      write_config(c);

      // receiver holds off while the sender keeps pushing: block fills and
      // cmd.ready has to drop
      if (ph == 4) hold_req = HOLD_CYCLES;

      run_left = 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // hold a command for a few words so the ramps get near their targets
        if (run_left == 0) begin
          pw       = pick_q15(c.power_deadzone);
          st       = pick_q15(c.steer_deadzone);
          run_left = $urandom_range(3) ? $urandom_range(1, 12) : 1;
        end
        // sender pause mid-phase until everything is back
        if ((ph == 3 || ph == 5) && k == PHASE_WORDS / 2) wait_drain();
        send_command(pw, st);
        run_left--;
      end
      wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("steer_differential_mixer_ramp_tb passed");
    end else begin
      $display("steer_differential_mixer_ramp_tb failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(WATCHDOG_NS);
    $display("steer_differential_mixer_ramp_tb failed");
    $finish;
  end

endmodule

>>> files.f
hdl/mdr_pkg.sv
hdl/mdr_if.sv
hdl/mdr_cfg.sv
hdl/mdr_mul.sv
hdl/mdr_tan_rom.sv
hdl/steer_differential_mixer_ramp.sv
verif/steer_differential_mixer_ramp_tb.sv
